/* hw/rtl/sbr_pkg.sv */
package sbr_pkg;

  localparam int unsigned PROG_SIZE  = 4096;
  localparam int unsigned OPEN_DEPTH = 32;
  localparam int unsigned COND_DEPTH = 16;

  localparam int unsigned IDX_W   = 12;
  localparam int unsigned ACT_W   = 4;
  localparam int unsigned ERR_W   = 4;
  localparam int unsigned TBL_AW  = $clog2(PROG_SIZE);
  localparam int unsigned TBL_DW  = IDX_W + 1;
  localparam int unsigned OPEN_AW = $clog2(OPEN_DEPTH);
  localparam int unsigned OPEN_CW = $clog2(OPEN_DEPTH + 1);
  localparam int unsigned COND_AW = $clog2(COND_DEPTH);
  localparam int unsigned COND_CW = $clog2(COND_DEPTH + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_B_IF       = 4'd0,
    ACT_B_ELIF     = 4'd1,
    ACT_B_ELSE     = 4'd2,
    ACT_B_ENDIF    = 4'd3,
    ACT_B_WHILE    = 4'd4,
    ACT_B_ENDWHILE = 4'd5,
    ACT_FINALIZE   = 4'd6,
    ACT_R_IF       = 4'd7,
    ACT_R_ELIF     = 4'd8,
    ACT_R_ELSE     = 4'd9,
    ACT_R_ENDIF    = 4'd10,
    ACT_R_WHILE    = 4'd11,
    ACT_R_ENDWHILE = 4'd12
  } act_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK            = 4'd0,
    ERR_BAD_ELSE      = 4'd1,
    ERR_BAD_ELIF      = 4'd2,
    ERR_ENDIF_WHILE   = 4'd3,
    ERR_ENDWHILE_IF   = 4'd4,
    ERR_NO_OPEN       = 4'd5,
    ERR_UNCLOSED      = 4'd6,
    ERR_OPEN_OVERFLOW = 4'd7,
    ERR_COND_OVERFLOW = 4'd8,
    ERR_NO_TARGET     = 4'd9
  } err_e;

  typedef enum logic [1:0] {
    KIND_IF    = 2'd0,
    KIND_ELIF  = 2'd1,
    KIND_ELSE  = 2'd2,
    KIND_WHILE = 2'd3
  } kind_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
    logic close;
    logic load;
    logic from_hold;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_close;
    logic close_last;
    logic out_free;
  } status_t;

endpackage

/* hw/rtl/sbr_ctrl.sv */
module sbr_ctrl
  import sbr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_CLOSE = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (st_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (st_i.need_close) begin
          state_d = ST_CLOSE;
        end else if (st_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_HOLD;
        end
      end
      ST_CLOSE: begin
        cmd_o.close = 1'b1;
        if (st_i.close_last) begin
          if (st_i.out_free) begin
            cmd_o.load = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (st_i.out_free) begin
          cmd_o.load      = 1'b1;
          cmd_o.from_hold = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/sbr_datapath.sv */
module sbr_datapath
  import sbr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          st_o,
  input  logic [ACT_W-1:0] action_i,
  input  logic [IDX_W-1:0] index_i,
  input  logic             cond_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IDX_W-1:0] next_index_o,
  output logic             jumped_o,
  output logic [ERR_W-1:0] error_o
);

  logic [TBL_DW-1:0] tbl_mem [PROG_SIZE];
  logic [TBL_DW-1:0] tbl_rdata_q;
  logic              tbl_rng_q;
  logic [TBL_AW-1:0] clr_cnt_q;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  logic [TBL_DW-1:0] tbl_wdata;
  logic [IDX_W-1:0]  tbl_widx;

  kind_e            open_kind_q [OPEN_DEPTH];
  logic [IDX_W-1:0] open_idx_q  [OPEN_DEPTH];
  logic [OPEN_CW-1:0] open_cnt_q, open_cnt_m1;
  logic [OPEN_AW-1:0] open_top_a, open_push_a;
  kind_e              top_kind;
  logic [IDX_W-1:0]   top_idx;

  logic               cond_stk_q [COND_DEPTH];
  logic [COND_CW-1:0] cond_cnt_q, cond_cnt_m1;
  logic [COND_AW-1:0] cond_top_a, cond_push_a;
  logic               cond_top;

  act_e             act_q;
  logic [IDX_W-1:0] idx_q;
  logic             cond_q;
  logic [IDX_W-1:0] link_q;

  logic             hit;
  logic             do_jump;
  err_e             err;
  logic             open_push;
  kind_e            push_kind;
  logic             cond_push;
  logic             cond_push_val;
  logic             cond_set;
  logic             cond_pop;
  logic             ex_we;
  logic [TBL_DW-1:0] ex_wdata;
  logic             need_close;
  logic             close_last;

  logic [IDX_W-1:0] res_idx_d, res_idx_q;
  logic             res_jmp_d, res_jmp_q;
  logic [ERR_W-1:0] res_err_d, res_err_q;
  logic             out_valid_q;

  assign open_cnt_m1 = open_cnt_q - OPEN_CW'(1);
  assign open_top_a  = open_cnt_m1[OPEN_AW-1:0];
  assign open_push_a = open_cnt_q[OPEN_AW-1:0];
  assign top_kind    = (open_cnt_q != '0) ? open_kind_q[open_top_a] : KIND_IF;
  assign top_idx     = open_idx_q[open_top_a];

  assign cond_cnt_m1 = cond_cnt_q - COND_CW'(1);
  assign cond_top_a  = cond_cnt_m1[COND_AW-1:0];
  assign cond_push_a = cond_cnt_q[COND_AW-1:0];
  assign cond_top    = cond_stk_q[cond_top_a];

  assign hit = tbl_rng_q && tbl_rdata_q[IDX_W];

  always_comb begin
    err           = ERR_OK;
    do_jump       = 1'b0;
    open_push     = 1'b0;
    push_kind     = KIND_IF;
    cond_push     = 1'b0;
    cond_push_val = cond_q;
    cond_set      = 1'b0;
    cond_pop      = 1'b0;
    ex_we         = 1'b0;
    ex_wdata      = '0;
    need_close    = 1'b0;
    case (act_q)
      ACT_B_IF, ACT_B_WHILE: begin
        push_kind = (act_q == ACT_B_IF) ? KIND_IF : KIND_WHILE;
        if (open_cnt_q >= OPEN_CW'(OPEN_DEPTH)) begin
          err = ERR_OPEN_OVERFLOW;
        end else begin
          open_push = 1'b1;
        end
      end
      ACT_B_ELIF, ACT_B_ELSE: begin
        push_kind = (act_q == ACT_B_ELIF) ? KIND_ELIF : KIND_ELSE;
        if (open_cnt_q == '0) begin
          err = ERR_NO_OPEN;
        end else if (top_kind == KIND_ELSE || top_kind == KIND_WHILE) begin
          err = (act_q == ACT_B_ELIF) ? ERR_BAD_ELIF : ERR_BAD_ELSE;
        end else if (open_cnt_q >= OPEN_CW'(OPEN_DEPTH)) begin
          err = ERR_OPEN_OVERFLOW;
        end else begin
          open_push = 1'b1;
        end
      end
      ACT_B_ENDIF: begin
        if (open_cnt_q == '0) begin
          err = ERR_NO_OPEN;
        end else if (top_kind == KIND_WHILE) begin
          err = ERR_ENDIF_WHILE;
        end else begin
          ex_we      = 1'b1;
          need_close = 1'b1;
        end
      end
      ACT_B_ENDWHILE: begin
        if (open_cnt_q == '0) begin
          err = ERR_NO_OPEN;
        end else if (top_kind != KIND_WHILE) begin
          err = ERR_ENDWHILE_IF;
        end else begin
          ex_we      = 1'b1;
          ex_wdata   = {1'b1, top_idx};
          need_close = 1'b1;
        end
      end
      ACT_FINALIZE: begin
        if (open_cnt_q != '0) begin
          err = ERR_UNCLOSED;
        end
      end
      ACT_R_IF, ACT_R_WHILE: begin
        if (cond_cnt_q >= COND_CW'(COND_DEPTH)) begin
          err = ERR_COND_OVERFLOW;
        end else if (!cond_q && !hit) begin
          err = ERR_NO_TARGET;
        end else begin
          do_jump   = !cond_q;
          cond_push = 1'b1;
        end
      end
      ACT_R_ELIF: begin
        if (cond_cnt_q != '0) begin
          if (cond_top || !cond_q) begin
            if (hit) begin
              do_jump = 1'b1;
            end else begin
              err = ERR_NO_TARGET;
            end
          end else begin
            cond_set = 1'b1;
          end
        end
      end
      ACT_R_ELSE: begin
        if (cond_cnt_q != '0 && cond_top) begin
          if (hit) begin
            do_jump = 1'b1;
          end else begin
            err = ERR_NO_TARGET;
          end
        end
      end
      ACT_R_ENDIF: begin
        cond_pop = (cond_cnt_q != '0);
      end
      ACT_R_ENDWHILE: begin
        if (cond_cnt_q != '0) begin
          if (cond_top && !hit) begin
            err = ERR_NO_TARGET;
          end else begin
            do_jump  = cond_top;
            cond_pop = 1'b1;
          end
        end
      end
      default: begin
        err = ERR_OK;
      end
    endcase
  end

  assign close_last = (open_kind_q[open_top_a] == KIND_IF) ||
                      (open_kind_q[open_top_a] == KIND_WHILE) || (open_cnt_m1 == '0);

  always_comb begin
    res_idx_d = idx_q;
    res_jmp_d = 1'b0;
    res_err_d = ERR_OK;
    if (cmd_i.exec) begin
      res_err_d = err;
      if (do_jump) begin
        res_idx_d = tbl_rdata_q[IDX_W-1:0] - IDX_W'(1);
        res_jmp_d = 1'b1;
      end
    end
  end

  always_comb begin
    tbl_we    = 1'b0;
    tbl_widx  = idx_q;
    tbl_wdata = ex_wdata;
    if (cmd_i.exec) begin
      tbl_we = ex_we;
    end else if (cmd_i.close) begin
      tbl_we    = 1'b1;
      tbl_widx  = top_idx;
      tbl_wdata = {1'b1, link_q};
    end
    tbl_waddr = TBL_AW'(tbl_widx);
    if (cmd_i.clear) begin
      tbl_waddr = clr_cnt_q;
      tbl_wdata = '0;
    end else if ({20'd0, tbl_widx} >= PROG_SIZE) begin
      tbl_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear || tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (cmd_i.accept) begin
      tbl_rdata_q <= tbl_mem[TBL_AW'(index_i)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      act_q     <= act_e'(action_i);
      idx_q     <= index_i;
      cond_q    <= cond_i;
      tbl_rng_q <= ({20'd0, index_i} < PROG_SIZE);
    end
    if (cmd_i.exec) begin
      link_q <= idx_q;
    end else if (cmd_i.close) begin
      link_q <= top_idx;
    end
    if (cmd_i.exec && open_push) begin
      open_kind_q[open_push_a] <= push_kind;
      open_idx_q[open_push_a]  <= idx_q;
    end
    if (cmd_i.exec && cond_push) begin
      cond_stk_q[cond_push_a] <= cond_push_val;
    end else if (cmd_i.exec && cond_set) begin
      cond_stk_q[cond_top_a] <= 1'b1;
    end
    if (cmd_i.exec || cmd_i.close) begin
      res_idx_q <= res_idx_d;
      res_jmp_q <= res_jmp_d;
      res_err_q <= res_err_d;
    end
    if (cmd_i.load) begin
      next_index_o <= cmd_i.from_hold ? res_idx_q : res_idx_d;
      jumped_o     <= cmd_i.from_hold ? res_jmp_q : res_jmp_d;
      error_o      <= cmd_i.from_hold ? res_err_q : res_err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      open_cnt_q  <= '0;
      cond_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + TBL_AW'(1);
      end
      if (cmd_i.exec && open_push) begin
        open_cnt_q <= open_cnt_q + OPEN_CW'(1);
      end else if (cmd_i.close) begin
        open_cnt_q <= open_cnt_m1;
      end
      if (cmd_i.exec && cond_push) begin
        cond_cnt_q <= cond_cnt_q + COND_CW'(1);
      end else if (cmd_i.exec && cond_pop) begin
        cond_cnt_q <= cond_cnt_m1;
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  assign st_o.clr_last   = (clr_cnt_q == TBL_AW'(PROG_SIZE - 1));
  assign st_o.need_close = need_close;
  assign st_o.close_last = close_last;
  assign st_o.out_free   = !out_valid_q || out_ready_i;

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_cnt_q <= OPEN_CW'(OPEN_DEPTH))
    else $error("open stack count beyond its depth");

  a_cond_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cond_cnt_q <= COND_CW'(COND_DEPTH))
    else $error("condition stack count beyond its depth");

  a_close_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.close |-> open_cnt_q != '0)
    else $error("block close with an empty open stack");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an item not yet taken");

  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !tbl_we && !cmd_i.clear)
    else $error("table written while a lookup is read");

endmodule

/* hw/rtl/structured_branch_resolver.sv */
// Resolves if/elif/else/endif and while/endwhile markers: build-phase items
// link each clause into a jump table, run-phase items return the index to
// continue from. After reset the jump table is cleared one entry at a time,
// during which no item is accepted. Afterwards each item is first latched
// with its table entry read, then decoded against the stack tops. A build
// endif or endwhile that closes a block then pops open-stack entries one at
// a time, each pop writing one table entry through the single write port.
// A new item is accepted while the previous result waits in the output
// register; an item finishes only when that register is free.
module structured_branch_resolver
  import sbr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ACT_W-1:0] action_i,
  input  logic [IDX_W-1:0] index_i,
  input  logic             cond_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IDX_W-1:0] next_index_o,
  output logic             jumped_o,
  output logic [ERR_W-1:0] error_o
);

  cmd_t    cmd;
  status_t st;

  sbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  sbr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .st_o         (st),
    .action_i     (action_i),
    .index_i      (index_i),
    .cond_i       (cond_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .next_index_o (next_index_o),
    .jumped_o     (jumped_o),
    .error_o      (error_o)
  );

endmodule
